[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/ist_pkg.sv]
// ----------------------------------------------------------------------------
// ist_pkg
// shared types, constants and the microcode rom of the integer set table
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_ALIAS  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_PRESENT   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE    = 3'd0,
      S_SCAN    = 3'd1,
      S_DECIDE  = 3'd2,
      S_APPEND  = 3'd3,
      S_CHK_REM = 3'd4,
      S_RD_LAST = 3'd5,
      S_MOVE    = 3'd6,
      S_EMIT    = 3'd7
   } step_type;

   typedef enum logic [2:0] {
      C_ALWAYS    = 3'd0,
      C_REQ       = 3'd1,
      C_SCAN_DONE = 3'd2,
      C_INS_OK    = 3'd3,
      C_REM_OK    = 3'd4,
      C_OUT_FREE  = 3'd5
   } cond_type;

   typedef struct packed {
      cond_type cond;
      step_type go_t;
      step_type go_f;
      logic     req_ready;
      logic     load;
      logic     scan;
      logic     decide;
      logic     append;
      logic     rd_last;
      logic     move;
      logic     emit;
   } ctl_type;

   typedef struct packed {
      logic req_fire;
      logic scan_done;
      logic ins_ok;
      logic rem_ok;
      logic out_free;
   } flags_type;

   function automatic ctl_type ist_rom(input step_type s);
      ctl_type w;
      w = '0;
      unique case (s)
         S_IDLE: begin
            w.cond = C_REQ; w.go_t = S_SCAN; w.go_f = S_IDLE;
            w.req_ready = 1'b1; w.load = 1'b1;
         end
         S_SCAN: begin
            w.cond = C_SCAN_DONE; w.go_t = S_DECIDE; w.go_f = S_SCAN;
            w.scan = 1'b1;
         end
         S_DECIDE: begin
            w.cond = C_INS_OK; w.go_t = S_APPEND; w.go_f = S_CHK_REM;
            w.decide = 1'b1;
         end
         S_APPEND: begin
            w.cond = C_ALWAYS; w.go_t = S_EMIT; w.go_f = S_EMIT;
            w.append = 1'b1;
         end
         S_CHK_REM: begin
            w.cond = C_REM_OK; w.go_t = S_RD_LAST; w.go_f = S_EMIT;
         end
         S_RD_LAST: begin
            w.cond = C_ALWAYS; w.go_t = S_MOVE; w.go_f = S_MOVE;
            w.rd_last = 1'b1;
         end
         S_MOVE: begin
            w.cond = C_ALWAYS; w.go_t = S_EMIT; w.go_f = S_EMIT;
            w.move = 1'b1;
         end
         S_EMIT: begin
            w.cond = C_OUT_FREE; w.go_t = S_IDLE; w.go_f = S_EMIT;
            w.emit = 1'b1;
         end
         default: begin
            w.cond = C_ALWAYS; w.go_t = S_IDLE; w.go_f = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[rtl/ist_store.sv]
// ----------------------------------------------------------------------------
// ist_store
// slot memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ist_store
   import ist_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [SLOT_AW-1:0] wr_addr,
   input  wire logic [VALUE_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [SLOT_AW-1:0] rd_addr,
   output logic      [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ist_seq.sv]
// ----------------------------------------------------------------------------
// ist_seq
// microcode sequencer: step counter, control rom and jump condition select
// ----------------------------------------------------------------------------
`default_nettype none

module ist_seq
   import ist_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire flags_type flags,
   output ctl_type        ctl
);

   step_type upc_ff;
   step_type upc_in;
   logic     take;

   always_comb begin
      ctl = ist_rom(upc_ff);
   end

   always_comb begin
      unique case (ctl.cond)
         C_ALWAYS:    take = 1'b1;
         C_REQ:       take = flags.req_fire;
         C_SCAN_DONE: take = flags.scan_done;
         C_INS_OK:    take = flags.ins_ok;
         C_REM_OK:    take = flags.rem_ok;
         C_OUT_FREE:  take = flags.out_free;
         default:     take = 1'b1;
      endcase
      upc_in = take ? ctl.go_t : ctl.go_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

[rtl/integer_set_table_top.sv]
// a miss scans every occupied slot, a hit stops at the matching slot, and a remove that hits
// then reads the last slot and moves it into the freed position before the result is raised
// one item at a time: the next request can transfer in the cycle in which the result is raised,
// and the result waits while an earlier one is held; the slot scan reads one slot per cycle
// reset: synchronous, clears the occupancy, the step counter and the result valid;
// slot contents are left as they are and are never read before being written
// ----------------------------------------------------------------------------
// integer_set_table_top
// set of distinct 32-bit integers in an unsorted slot array with linear scan
// ----------------------------------------------------------------------------
`default_nettype none

module integer_set_table_top
   import ist_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // present[0], status[2:1], count[9:3], zero
);

   ctl_type            ctl;
   flags_type          flags;

   op_type             op_ff, op_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [SLOT_AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [SLOT_AW-1:0] pos_ff, pos_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   logic               wr_en, rd_en;
   logic [SLOT_AW-1:0] wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data, rd_data;
   logic               scan_issue, match;
   logic [OCC_W-1:0]   occ_dec;

   ist_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   ist_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = ctl.req_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign occ_dec    = occ_ff - 1'b1;
   assign scan_issue = ctl.scan && (rd_idx_ff != occ_ff);
   assign match      = cmp_vld_ff && (rd_data == key_ff);

   always_comb begin
      flags.req_fire  = req_tvalid && ctl.req_ready;
      flags.scan_done = match || (!cmp_vld_ff && (rd_idx_ff == occ_ff));
      flags.ins_ok    = (op_ff == OP_INSERT) && !hit_ff && (occ_ff < OCC_W'(CAPACITY));
      flags.rem_ok    = (op_ff == OP_REMOVE) && hit_ff;
      flags.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // slot memory port steering
   always_comb begin
      wr_en   = ctl.append || ctl.move;
      wr_addr = ctl.move ? pos_ff : occ_ff[SLOT_AW-1:0];
      wr_data = ctl.move ? rd_data : key_ff;
      rd_en   = scan_issue || ctl.rd_last;
      rd_addr = ctl.rd_last ? occ_dec[SLOT_AW-1:0] : rd_idx_ff[SLOT_AW-1:0];
   end

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      occ_in       = occ_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (ctl.load) begin
         op_in     = op_type'(req_tuser);
         key_in    = req_tdata;
         rd_idx_in = '0;
         hit_in    = 1'b0;
      end
      if (scan_issue) begin
         rd_idx_in  = rd_idx_ff + 1'b1;
         cmp_vld_in = 1'b1;
         cmp_idx_in = rd_idx_ff[SLOT_AW-1:0];
      end
      if (ctl.scan && match) begin
         hit_in = 1'b1;
         pos_in = cmp_idx_ff;
      end
      if (ctl.decide) begin
         unique case (op_ff)
            OP_INSERT: begin
               priority if (hit_ff) begin
                  status_in = ST_PRESENT;
               end else if (occ_ff >= OCC_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_DONE;
               end
            end
            default: status_in = hit_ff ? ST_DONE : ST_NOT_FOUND;
         endcase
      end
      if (ctl.append) begin
         occ_in = occ_ff + 1'b1;
      end
      if (ctl.rd_last) begin
         occ_in = occ_dec;
      end
      if (ctl.emit && flags.out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, COUNT_W'(occ_ff), status_ff, hit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[rtl/ist_checker.sv]
// ----------------------------------------------------------------------------
// ist_checker
// port-level checks of the integer set table results
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ist_checker
   import ist_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   logic [1:0]         status;
   logic [COUNT_W-1:0] count;
   logic               present;
   logic               full_rsp;
   logic               full_ok;
   logic               code_rsp;
   logic               present_ok;

   assign present    = rsp_tdata[0];
   assign status     = rsp_tdata[2:1];
   assign count      = rsp_tdata[9:3];
   assign full_rsp   = rsp_tvalid && (status == ST_FULL);
   assign full_ok    = (count == COUNT_W'(CAPACITY)) && !present;
   assign code_rsp   = rsp_tvalid && (status == ST_PRESENT || status == ST_NOT_FOUND);
   assign present_ok = present == (status == ST_PRESENT);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_IMPLIES(a_count_max, clock, reset, rsp_tvalid, count <= COUNT_W'(CAPACITY))
   `ASSERT_IMPLIES(a_full_count, clock, reset, full_rsp, full_ok)
   `ASSERT_IMPLIES(a_status_present, clock, reset, code_rsp, present_ok)

endmodule

bind integer_set_table_top ist_checker u_ist_checker (.*);

`default_nettype wire
